// File: rtl/filled_circle_span_generator_defines.svh
// assertion macros used by the checker file
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_DEFINES_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_DEFINES_SVH

// property checked outside reset
`define FCSG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fcsg assertion failed");

// property checked on every edge, reset included
`define FCSG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fcsg assertion failed");

`endif

// File: rtl/fcsg_pkg.sv
package fcsg_pkg;

    localparam int MAX_RADIUS = 20;
    localparam int CX_W       = 9;
    localparam int RAD_W      = 5;
    localparam int COLOR_W    = 16;
    localparam int SPAN_W     = 10;
    // offset counters x and y, signed (y may drop to -1 after the final step)
    localparam int OFS_W      = 7;
    // decision value
    localparam int DEC_W      = 10;

    localparam int DEC_INIT    = 3;
    localparam int DEC_INC_NEG = 6;
    localparam int DEC_INC_POS = 10;

    // span order inside one iteration
    localparam logic [1:0] PH_ROW_PY = 2'd0;
    localparam logic [1:0] PH_ROW_MY = 2'd1;
    localparam logic [1:0] PH_ROW_PX = 2'd2;
    localparam logic [1:0] PH_ROW_MX = 2'd3;

    typedef struct packed {
        logic load;   // take a new request
        logic emit;   // compute one span into the output register
    } t_cmd;

    typedef struct packed {
        logic last_span;  // span about to be emitted is the final one
    } t_stat;

endpackage

// File: rtl/filled_circle_span_generator.sv
// filled circle span generator
//
// input channel (i_valid / o_ready): one circle request per transfer with
// center column, center row, radius and an rgb565 color. radii above 20 are
// clamped to 20.
// output channel (o_valid / i_ready): one horizontal span per transfer, with
// both endpoint columns, the row, the color and o_last_span on the final
// span. spans come four per midpoint iteration: rows cy+y, cy-y, cy+x, cy-x.
//
// request path: the request is latched into the datapath registers and the first
// span is computed from them into the output register. throughput: one span per
// cycle while i_ready does not stall the output, set by the single decision/offset
// update unit in the datapath; a request yielding n spans (4 to 60) keeps the
// block busy until its final span is computed. o_ready is high whenever no request
// is in work, also while the final span still waits in the output register.
// receiver stall: the output register holds its span and the iteration
// pauses until i_ready rises.
// reset: synchronous active low, holds o_ready low, drops o_valid and returns
// to idle; a request in work is abandoned.
module filled_circle_span_generator
    import fcsg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic       [CX_W-1:0]     i_center_x,
    input  logic       [CX_W-1:0]     i_center_y,
    input  logic       [RAD_W-1:0]    i_radius,
    input  logic       [COLOR_W-1:0]  i_fill_color,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [SPAN_W-1:0]  o_span_x_from,
    output logic signed [SPAN_W-1:0]  o_span_x_to,
    output logic signed [SPAN_W-1:0]  o_span_row,
    output logic       [COLOR_W-1:0]  o_span_color,
    output logic                      o_last_span
);

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: idle/run control and output valid
    fcsg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: request latch, midpoint stepping, span output register
    fcsg_dpath u_dpath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_fill_color  (i_fill_color),
        .o_stat        (stat),
        .o_span_x_from (o_span_x_from),
        .o_span_x_to   (o_span_x_to),
        .o_span_row    (o_span_row),
        .o_span_color  (o_span_color),
        .o_last_span   (o_last_span)
    );

endmodule

// File: rtl/fcsg_dpath.sv
module fcsg_dpath
    import fcsg_pkg::*;
(
    input  logic                       i_clk,
    input  t_cmd                       i_cmd,
    input  logic        [CX_W-1:0]     i_center_x,
    input  logic        [CX_W-1:0]     i_center_y,
    input  logic        [RAD_W-1:0]    i_radius,
    input  logic        [COLOR_W-1:0]  i_fill_color,
    output t_stat                      o_stat,
    output logic signed [SPAN_W-1:0]   o_span_x_from,
    output logic signed [SPAN_W-1:0]   o_span_x_to,
    output logic signed [SPAN_W-1:0]   o_span_row,
    output logic        [COLOR_W-1:0]  o_span_color,
    output logic                       o_last_span
);

    logic        [CX_W-1:0]    r_cx, r_cy;
    logic        [COLOR_W-1:0] r_color;
    logic signed [OFS_W-1:0]   r_x, r_y;
    logic signed [DEC_W-1:0]   r_d;
    logic        [1:0]         r_phase;

    logic signed [SPAN_W-1:0]  r_span_from, r_span_to, r_span_row;
    logic        [COLOR_W-1:0] r_span_color;
    logic                      r_last;

    logic        [RAD_W-1:0]   rad_sat;
    logic signed [OFS_W-1:0]   ofs_col, ofs_row;
    logic signed [SPAN_W-1:0]  cx_ext, cy_ext, col_ext, row_ext;
    logic signed [SPAN_W-1:0]  span_from, span_to, span_row;
    logic signed [DEC_W-1:0]   x_ext, y_ext, d_neg, d_pos;
    logic signed [OFS_W-1:0]   n_x, n_y;
    logic signed [DEC_W-1:0]   n_d;
    logic                      last_iter;

    // radius saturation
    assign rad_sat = (i_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : i_radius;

    // span geometry: rows cy+-y use offset x, rows cy+-x use offset y
    assign ofs_col = r_phase[1] ? r_y : r_x;
    assign ofs_row = r_phase[1] ? r_x : r_y;
    assign cx_ext  = signed'({1'b0, r_cx});
    assign cy_ext  = signed'({1'b0, r_cy});
    assign col_ext = SPAN_W'(ofs_col);
    assign row_ext = SPAN_W'(ofs_row);
    assign span_from = cx_ext + col_ext;
    assign span_to   = cx_ext - col_ext;
    assign span_row  = r_phase[0] ? (cy_ext - row_ext) : (cy_ext + row_ext);

    // midpoint decision update
    assign x_ext = DEC_W'(r_x);
    assign y_ext = DEC_W'(r_y);
    assign d_neg = r_d + (x_ext <<< 2) + DEC_W'(DEC_INC_NEG);
    assign d_pos = r_d + ((x_ext - y_ext) <<< 2) + DEC_W'(DEC_INC_POS);

    always_comb begin
        n_x = r_x + OFS_W'(1);
        if (r_d[DEC_W-1]) begin
            n_d = d_neg;
            n_y = r_y;
        end else begin
            n_d = d_pos;
            n_y = r_y - OFS_W'(1);
        end
    end

    assign last_iter        = (n_x > n_y);
    assign o_stat.last_span = (r_phase == PH_ROW_MX) && last_iter;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_color <= i_fill_color;
            r_x     <= '0;
            r_y     <= signed'(OFS_W'(rad_sat));
            r_d     <= DEC_W'(DEC_INIT) - DEC_W'({rad_sat, 1'b0});
            r_phase <= PH_ROW_PY;
        end else if (i_cmd.emit) begin
            r_phase <= r_phase + 2'd1;
            if (r_phase == PH_ROW_MX) begin
                r_x <= n_x;
                r_y <= n_y;
                r_d <= n_d;
            end
        end
        if (i_cmd.emit) begin
            r_span_from  <= span_from;
            r_span_to    <= span_to;
            r_span_row   <= span_row;
            r_span_color <= r_color;
            r_last       <= o_stat.last_span;
        end
    end

    assign o_span_x_from = r_span_from;
    assign o_span_x_to   = r_span_to;
    assign o_span_row    = r_span_row;
    assign o_span_color  = r_span_color;
    assign o_last_span   = r_last;

endmodule

// File: rtl/fcsg_ctrl.sv
module fcsg_ctrl
    import fcsg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // output register can take a span when empty or being drained
    assign out_free   = !r_out_valid || i_ready;
    // no request is taken while reset is held
    assign o_ready    = (r_state == S_IDLE) && i_rst_n;
    assign o_cmd.load = o_ready && i_valid;
    assign o_cmd.emit = (r_state == S_RUN) && out_free;
    assign o_valid    = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (o_cmd.emit && i_stat.last_span) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/fcsg_checker.sv
`include "filled_circle_span_generator_defines.svh"

module fcsg_checker
    import fcsg_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic signed [SPAN_W-1:0]  o_span_x_from,
    input logic signed [SPAN_W-1:0]  o_span_x_to,
    input logic signed [SPAN_W-1:0]  o_span_row,
    input logic       [COLOR_W-1:0]  o_span_color,
    input logic                      o_last_span
);

    // reset empties the output register
    `FCSG_ASSERT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n |=> !o_valid)

    // a stalled span holds
    `FCSG_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_valid && !i_ready |=> o_valid && $stable(o_span_x_from) &&
        $stable(o_span_x_to) && $stable(o_span_row) && $stable(o_span_color) &&
        $stable(o_last_span))

    // a taken request leaves the block busy in the next cycle
    `FCSG_ASSERT(a_busy_after_req, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)

    // while a non-final span is shown the request is still in work
    `FCSG_ASSERT(a_busy_mid_circle, i_clk, i_rst_n, o_valid && !o_last_span |-> !o_ready)

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_span_x_from (o_span_x_from),
    .o_span_x_to   (o_span_x_to),
    .o_span_row    (o_span_row),
    .o_span_color  (o_span_color),
    .o_last_span   (o_last_span)
);
